// File: design/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg: shared types and constants for the particle state integrator
// Register indexes, field widths and the per-stage record types.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivStages = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY_X   = 3'd0,
    REG_GRAVITY_Y   = 3'd1,
    REG_GRAVITY_Z   = 3'd2,
    REG_DRAG_RATE   = 3'd3,
    REG_COLOR_START = 3'd4,
    REG_COLOR_END   = 3'd5,
    REG_SIZE_START  = 3'd6,
    REG_SIZE_END    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
    logic [23:0]        drag;
    logic [31:0]        col_s;
    logic [31:0]        col_e;
    logic [31:0]        siz_s;
    logic [31:0]        siz_e;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        dt;
    logic               alive;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        age;
    logic [31:0]        span;
    logic [15:0]        spin;
    logic signed [23:0] rate;
  } rec_t;

  typedef struct packed {
    logic               live;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        nage;
    logic [15:0]        spin;
  } kin_t;

  typedef struct packed {
    logic [31:0] tint;
    logic [31:0] extent;
  } look_t;

  // floor(a*b/2^16) for a signed 33-bit value and an unsigned 17-bit factor
  function automatic logic signed [33:0] mul_fl(input logic signed [32:0] a,
                                                input logic [16:0] b);
    logic signed [50:0] p;
    p = 51'(a) * $signed({1'b0, b});
    return 34'(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) return 32'sh7fffffff;
    if (x < -34'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

endpackage

// File: design/particle_state_integrator_unit.sv
// ----------------------------------------------------------------------------
// particle_state_integrator_unit: streaming particle update
// Usage:
//  - in_* channel: one particle record per transaction (valid/ready).
//  - out_* channel: one updated record per input transaction, in order.
//  - cfg_* channel: register writes (index, data); write only while idle.
//    Indexes beyond the register list are ignored.
// Throughput: one record per cycle while the skid buffer has a free slot.
// The input-to-output delay is set by the 16-stage restoring divider that
//  forms age/life_span (one quotient bit per stage) plus lerp and padding.
// The whole pipeline advances together; a stalled receiver freezes it, and
// a two-entry skid buffer at the output keeps in_ready registered and lets
// a new record enter while a finished one still waits.
// Reset (synchronous, rst_n low) clears valid bits and loads the register
// reset values; payload registers are not reset.
// ----------------------------------------------------------------------------
module particle_state_integrator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_step_time,
  input  logic               in_is_alive,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [31:0]        in_age,
  input  logic [31:0]        in_life_span,
  input  logic [15:0]        in_spin_angle,
  input  logic signed [23:0] in_spin_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_still_alive,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic [31:0]        out_new_age,
  output logic [15:0]        out_new_spin_angle,
  output logic [31:0]        out_tint,
  output logic [31:0]        out_extent,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import psi_pkg::*;

  localparam int unsigned Lat = DivStages + 2;

  cfg_t  cfg_r;
  rec_t  rec;
  kin_t  kin;
  look_t look;

  // --- configuration registers ---
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grav_x <= '0;
      cfg_r.grav_y <= '0;
      cfg_r.grav_z <= '0;
      cfg_r.drag   <= '0;
      cfg_r.col_s  <= 32'hffffffff;
      cfg_r.col_e  <= 32'hffffff00;
      cfg_r.siz_s  <= 32'h00800080;
      cfg_r.siz_e  <= 32'h001a001a;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GRAVITY_X:   cfg_r.grav_x <= cfg_data;
        REG_GRAVITY_Y:   cfg_r.grav_y <= cfg_data;
        REG_GRAVITY_Z:   cfg_r.grav_z <= cfg_data;
        REG_DRAG_RATE:   cfg_r.drag   <= cfg_data[23:0];
        REG_COLOR_START: cfg_r.col_s  <= cfg_data;
        REG_COLOR_END:   cfg_r.col_e  <= cfg_data;
        REG_SIZE_START:  cfg_r.siz_s  <= cfg_data;
        REG_SIZE_END:    cfg_r.siz_e  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- pipeline control ---
  // The pipeline moves when the skid buffer has a free slot. Two slots
  // guarantee that the item leaving the pipeline always finds room.
  logic [Lat-1:0] vld_r;
  logic [1:0]     cnt_r;
  logic           adv;
  logic           take;
  logic           pop;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    rec.dt    = in_step_time;
    rec.alive = in_is_alive;
    rec.pos_x = in_pos_x;
    rec.pos_y = in_pos_y;
    rec.pos_z = in_pos_z;
    rec.vel_x = in_vel_x;
    rec.vel_y = in_vel_y;
    rec.vel_z = in_vel_z;
    rec.age   = in_age;
    rec.span  = in_life_span;
    rec.spin  = in_spin_angle;
    rec.rate  = in_spin_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], take};
    end
  end

  psi_kin u_kin (
    .clk   (clk),
    .adv   (adv),
    .cfg   (cfg_r),
    .rec   (rec),
    .kin   (kin)
  );

  psi_look u_look (
    .clk  (clk),
    .adv  (adv),
    .cfg  (cfg_r),
    .rec  (rec),
    .look (look)
  );

  // --- output skid buffer, two entries ---
  typedef struct packed {
    kin_t  k;
    look_t l;
  } res_t;

  res_t       buf_r [2];
  logic       rd_r, wr_r;
  logic       push;

  assign push = adv && vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r].k <= kin;
      buf_r[wr_r].l <= look;
    end
  end

  assign out_valid          = (cnt_r != 2'd0);
  assign out_still_alive    = buf_r[rd_r].k.live;
  assign out_new_pos_x      = buf_r[rd_r].k.pos_x;
  assign out_new_pos_y      = buf_r[rd_r].k.pos_y;
  assign out_new_pos_z      = buf_r[rd_r].k.pos_z;
  assign out_new_vel_x      = buf_r[rd_r].k.vel_x;
  assign out_new_vel_y      = buf_r[rd_r].k.vel_y;
  assign out_new_vel_z      = buf_r[rd_r].k.vel_z;
  assign out_new_age        = buf_r[rd_r].k.nage;
  assign out_new_spin_angle = buf_r[rd_r].k.spin;
  assign out_tint           = buf_r[rd_r].l.tint;
  assign out_extent         = buf_r[rd_r].l.extent;
endmodule

// File: design/psi_kin.sv
// ----------------------------------------------------------------------------
// psi_kin: motion pipeline
// Stages: age/gravity, drag, position, then an align delay line. Advances on adv.
// ----------------------------------------------------------------------------
module psi_kin (
  input  logic           clk,
  input  logic           adv,
  input  psi_pkg::cfg_t  cfg,
  input  psi_pkg::rec_t  rec,
  output psi_pkg::kin_t  kin
);
  import psi_pkg::*;

  // stage 1: age, gravity, drag factor
  rec_t        s1_r;
  logic        s1_live_r;
  logic [31:0] s1_nage_r;
  logic [16:0] s1_f_r;
  logic        s1_drag_r;
  logic signed [31:0] s1_vx_r, s1_vy_r, s1_vz_r;
  // stage 2: drag applied
  rec_t        s2_r;
  logic        s2_live_r;
  logic [31:0] s2_nage_r;
  logic signed [31:0] s2_vx_r, s2_vy_r, s2_vz_r;
  // stage 3: position, spin
  kin_t        s3_r;

  logic [32:0] age_sum;
  logic [31:0] nage_nxt;
  logic signed [33:0] df;
  logic signed [33:0] dprod;

  always_comb begin
    age_sum  = {1'b0, rec.age} + 33'(rec.dt);
    nage_nxt = rec.alive ? (age_sum[32] ? 32'hffffffff : age_sum[31:0]) : rec.age;
    dprod    = mul_fl($signed({9'd0, cfg.drag}), {1'b0, rec.dt});
    df       = 34'sd65536 - dprod;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= rec;
      s1_live_r <= rec.alive && (nage_nxt < rec.span);
      s1_nage_r <= nage_nxt;
      s1_drag_r <= (cfg.drag != '0);
      s1_f_r    <= (df < 0) ? 17'd0 : 17'(df);
      s1_vx_r   <= sat32(34'(rec.vel_x) + mul_fl(33'(cfg.grav_x), {1'b0, rec.dt}));
      s1_vy_r   <= sat32(34'(rec.vel_y) + mul_fl(33'(cfg.grav_y), {1'b0, rec.dt}));
      s1_vz_r   <= sat32(34'(rec.vel_z) + mul_fl(33'(cfg.grav_z), {1'b0, rec.dt}));

      s2_r      <= s1_r;
      s2_live_r <= s1_live_r;
      s2_nage_r <= s1_nage_r;
      if (!s1_live_r) begin
        s2_vx_r <= s1_r.vel_x;
        s2_vy_r <= s1_r.vel_y;
        s2_vz_r <= s1_r.vel_z;
      end else if (s1_drag_r) begin
        s2_vx_r <= 32'(mul_fl(33'(s1_vx_r), s1_f_r));
        s2_vy_r <= 32'(mul_fl(33'(s1_vy_r), s1_f_r));
        s2_vz_r <= 32'(mul_fl(33'(s1_vz_r), s1_f_r));
      end else begin
        s2_vx_r <= s1_vx_r;
        s2_vy_r <= s1_vy_r;
        s2_vz_r <= s1_vz_r;
      end

      s3_r.live  <= s2_live_r;
      s3_r.nage  <= s2_nage_r;
      s3_r.vel_x <= s2_vx_r;
      s3_r.vel_y <= s2_vy_r;
      s3_r.vel_z <= s2_vz_r;
      if (s2_live_r) begin
        s3_r.pos_x <= sat32(34'(s2_r.pos_x) + mul_fl(33'(s2_vx_r), {1'b0, s2_r.dt}));
        s3_r.pos_y <= sat32(34'(s2_r.pos_y) + mul_fl(33'(s2_vy_r), {1'b0, s2_r.dt}));
        s3_r.pos_z <= sat32(34'(s2_r.pos_z) + mul_fl(33'(s2_vz_r), {1'b0, s2_r.dt}));
        s3_r.spin  <= s2_r.spin + 16'(mul_fl(33'(s2_r.rate), {1'b0, s2_r.dt}));
      end else begin
        s3_r.pos_x <= s2_r.pos_x;
        s3_r.pos_y <= s2_r.pos_y;
        s3_r.pos_z <= s2_r.pos_z;
        s3_r.spin  <= s2_r.spin;
      end
    end
  end

  // delay line to meet the divider latency
  localparam int unsigned KinDly = DivStages + 2 - 3;
  kin_t dly_r [KinDly];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= s3_r;
      for (int i = 1; i < KinDly; i++) dly_r[i] <= dly_r[i-1];
    end
  end
  assign kin = dly_r[KinDly-1];
endmodule

// File: design/psi_look.sv
// ----------------------------------------------------------------------------
// psi_look: age ratio and colour/size lerp
// Restoring divider, one quotient bit per stage, then a lerp stage.
// ----------------------------------------------------------------------------
module psi_look (
  input  logic           clk,
  input  logic           adv,
  input  psi_pkg::cfg_t  cfg,
  input  psi_pkg::rec_t  rec,
  output psi_pkg::look_t look
);
  import psi_pkg::*;

  // stage 0: capture numerator nage<<16 and divisor
  logic [47:0] num0;
  logic [32:0] age_sum;
  logic [31:0] nage;
  always_comb begin
    age_sum = {1'b0, rec.age} + 33'(rec.dt);
    nage    = age_sum[32] ? 32'hffffffff : age_sum[31:0];
    num0    = {nage, 16'd0};
  end

  // quotient is below 2^16 when live, so only 16 bits are needed; the top 32
  // of the 48 dividend bits are preloaded and only the low 16 are restored.
  logic [32:0] rem_r [DivStages/2+1];
  logic [47:0] num_r [DivStages/2+1];
  logic [31:0] den_r [DivStages/2+1];
  logic [15:0] q_r   [DivStages/2+1];
  logic        lv_r  [DivStages/2+1];
  logic [31:0] cs_r  [DivStages/2+1];
  logic [31:0] ce_r  [DivStages/2+1];
  logic [31:0] ss_r  [DivStages/2+1];
  logic [31:0] se_r  [DivStages/2+1];

  localparam int unsigned DS = DivStages / 2;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {1'b0, num0[47:16]};
      num_r[0] <= num0;
      den_r[0] <= rec.span;
      q_r[0]   <= '0;
      lv_r[0]  <= rec.alive && (nage < rec.span);
      cs_r[0]  <= cfg.col_s;
      ce_r[0]  <= cfg.col_e;
      ss_r[0]  <= cfg.siz_s;
      se_r[0]  <= cfg.siz_e;
      for (int i = 1; i <= DS; i++) begin
        logic [33:0] sh;
        logic [33:0] df;
        sh = {rem_r[i-1], num_r[i-1][DS-i]};
        df = sh - 34'(den_r[i-1]);
        if (!df[33]) begin
          rem_r[i] <= 33'(df);
          q_r[i]   <= {q_r[i-1][14:0], 1'b1};
        end else begin
          rem_r[i] <= 33'(sh);
          q_r[i]   <= {q_r[i-1][14:0], 1'b0};
        end
        num_r[i] <= num_r[i-1];
        den_r[i] <= den_r[i-1];
        lv_r[i]  <= lv_r[i-1];
        cs_r[i]  <= cs_r[i-1];
        ce_r[i]  <= ce_r[i-1];
        ss_r[i]  <= ss_r[i-1];
        se_r[i]  <= se_r[i-1];
      end
    end
  end

  // Since nage < span when live, the top 32 bits stay below span;
  // the remaining 16 bits yield the quotient.
  logic [31:0] tint_nxt, ext_nxt;
  logic [16:0] t;
  always_comb begin
    t = {1'b0, q_r[DS]};
    for (int c = 0; c < 4; c++) begin
      logic signed [32:0] d;
      d = 33'(ce_r[DS][8*c +: 8]) - 33'(cs_r[DS][8*c +: 8]);
      tint_nxt[8*c +: 8] = cs_r[DS][8*c +: 8] + 8'(mul_fl(d, t));
    end
    for (int h = 0; h < 2; h++) begin
      logic signed [32:0] d;
      d = 33'(se_r[DS][16*h +: 16]) - 33'(ss_r[DS][16*h +: 16]);
      ext_nxt[16*h +: 16] = ss_r[DS][16*h +: 16] + 16'(mul_fl(d, t));
    end
  end

  look_t lk_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      lk_r.tint   <= lv_r[DS] ? tint_nxt : '0;
      lk_r.extent <= lv_r[DS] ? ext_nxt : '0;
    end
  end

  // pad to the common latency
  localparam int unsigned LkDly = DivStages + 2 - DS - 2;
  look_t dly_r [LkDly];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= lk_r;
      for (int i = 1; i < LkDly; i++) dly_r[i] <= dly_r[i-1];
    end
  end
  assign look = dly_r[LkDly-1];
endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle state integrator testbench
// Streams particle records through the unit with random gaps and stalls,
// predicts every updated record in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import psi_pkg::*;

  typedef struct {
    logic        live;
    logic [31:0] px, py, pz, vx, vy, vz, nage;
    logic [15:0] spin;
    logic [31:0] tint, extent;
  } upd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_step_time = '0;
  logic               in_is_alive = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [31:0]        in_age = '0, in_life_span = '0;
  logic [15:0]        in_spin_angle = '0;
  logic signed [23:0] in_spin_rate = '0;

  // result channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_still_alive;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic [31:0]        out_new_age;
  logic [15:0]        out_new_spin_angle;
  logic [31:0]        out_tint, out_extent;

  // register write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow copy of the register file
  logic signed [31:0] grav [3];
  logic [23:0]        drag_q;
  logic [31:0]        col_s_q, col_e_q, siz_s_q, siz_e_q;

  rec_t pending_recs[$];   // records waiting for the driver
  upd_t expected_upd[$];   // predicted records, oldest first
  int   errors = 0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   hold_off = 0;      // long receiver stall, counted down in its own process
  bit   stim_done = 1'b0;

  particle_state_integrator_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction, all arithmetic done in 64-bit signed terms
  // --------------------------------------------------------------------------
  function automatic longint floor_q16(longint x);
    return x >>> 16;   // arithmetic shift is floor
  endfunction

  function automatic longint clamp_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint blend(longint s, longint e, longint t);
    return s + floor_q16((e - s) * t);
  endfunction

  function automatic upd_t integrate(rec_t r);
    upd_t   u;
    longint dt, p[3], v[3], f, t, nage, span;
    logic [31:0] tn, ex;
    dt = longint'(r.dt);
    p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
    v[0] = r.vel_x; v[1] = r.vel_y; v[2] = r.vel_z;
    span = longint'(r.span);
    nage = longint'(r.age);
    u.spin = r.spin;
    u.live = 1'b0;
    tn = '0;
    ex = '0;
    if (r.alive) begin
      nage = nage + dt;
      if (nage > 64'hFFFFFFFF) nage = 64'hFFFFFFFF;
      if (nage < span) begin
        u.live = 1'b1;
        for (int i = 0; i < 3; i++) v[i] = clamp_s32(v[i] + floor_q16(grav[i] * dt));
        if (drag_q != 0) begin
          f = 65536 - floor_q16(longint'(drag_q) * dt);
          if (f < 0) f = 0;
          for (int i = 0; i < 3; i++) v[i] = floor_q16(v[i] * f);
        end
        for (int i = 0; i < 3; i++) p[i] = clamp_s32(p[i] + floor_q16(v[i] * dt));
        u.spin = 16'(longint'(r.spin) + floor_q16(longint'(r.rate) * dt));
        t = (nage << 16) / span;
        for (int i = 0; i < 4; i++)
          tn[8*i +: 8] = 8'(blend(col_s_q[8*i +: 8], col_e_q[8*i +: 8], t));
        for (int i = 0; i < 2; i++)
          ex[16*i +: 16] = 16'(blend(siz_s_q[16*i +: 16], siz_e_q[16*i +: 16], t));
      end
    end
    u.px = 32'(p[0]); u.py = 32'(p[1]); u.pz = 32'(p[2]);
    u.vx = 32'(v[0]); u.vy = 32'(v[1]); u.vz = 32'(v[2]);
    u.nage = 32'(nage);
    u.tint = tn;
    u.extent = ex;
    return u;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one queued record per transaction, random gap before each
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_upd.insert(expected_upd.size(), integrate(pending_recs.pop_front()));
      in_wait = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) in_wait = 0;
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (pending_recs.size() > 0 && in_wait == 0 &&
          !(in_valid && in_ready && pending_recs.size() == 0)) begin
        in_valid      <= 1'b1;
        in_step_time  <= pending_recs[0].dt;
        in_is_alive   <= pending_recs[0].alive;
        in_pos_x      <= pending_recs[0].pos_x;
        in_pos_y      <= pending_recs[0].pos_y;
        in_pos_z      <= pending_recs[0].pos_z;
        in_vel_x      <= pending_recs[0].vel_x;
        in_vel_y      <= pending_recs[0].vel_y;
        in_vel_z      <= pending_recs[0].vel_z;
        in_age        <= pending_recs[0].age;
        in_life_span  <= pending_recs[0].span;
        in_spin_angle <= pending_recs[0].spin;
        in_spin_rate  <= pending_recs[0].rate;
      end else begin
        in_valid <= 1'b0;
        if (in_wait > 0) in_wait = in_wait - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random receiver stalls, compare each result transaction
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // long receiver stall counter
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk) begin
    upd_t w;
    if (out_valid && out_ready) begin
      if (expected_upd.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual age %h", $time, out_new_age);
      end else begin
        w = expected_upd.pop_front();
        check_field("still_alive", 32'(out_still_alive), 32'(w.live));
        check_field("new_pos_x", out_new_pos_x, w.px);
        check_field("new_pos_y", out_new_pos_y, w.py);
        check_field("new_pos_z", out_new_pos_z, w.pz);
        check_field("new_vel_x", out_new_vel_x, w.vx);
        check_field("new_vel_y", out_new_vel_y, w.vy);
        check_field("new_vel_z", out_new_vel_z, w.vz);
        check_field("new_age", out_new_age, w.nage);
        check_field("new_spin_angle", 32'(out_new_spin_angle), 32'(w.spin));
        check_field("tint", out_tint, w.tint);
        check_field("extent", out_extent, w.extent);
      end
      out_wait = $urandom_range(0, 19);
      if ($urandom_range(0, 2) == 0) out_wait = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait = out_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_rec(rec_t r);
    pending_recs.insert(pending_recs.size(), r);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRAVITY_X:   grav[0] = data;
      REG_GRAVITY_Y:   grav[1] = data;
      REG_GRAVITY_Z:   grav[2] = data;
      REG_DRAG_RATE:   drag_q = data[23:0];
      REG_COLOR_START: col_s_q = data;
      REG_COLOR_END:   col_e_q = data;
      REG_SIZE_START:  siz_s_q = data;
      default:         siz_e_q = data;
    endcase
  endtask

  // wait until every queued record is sent and every result is back
  task automatic drain();
    while (pending_recs.size() != 0 || in_valid || expected_upd.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] edgy32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r.dt    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    r.alive = ($urandom_range(0, 7) != 0);
    r.pos_x = edgy32(); r.pos_y = edgy32(); r.pos_z = edgy32();
    r.vel_x = edgy32(); r.vel_y = edgy32(); r.vel_z = edgy32();
    r.span  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h000A0000);
    case ($urandom_range(0, 4))
      0:       r.age = $urandom;
      1:       r.age = 32'hFFFFFFFF - $urandom_range(0, 70000);
      default: r.age = (r.span == 0) ? 0 : $urandom_range(0, r.span);
    endcase
    r.spin  = 16'($urandom);
    r.rate  = 24'($urandom);
    return r;
  endfunction

  function automatic rec_t mk(logic [15:0] dt, logic alive, logic [31:0] p, logic [31:0] v,
                              logic [31:0] age, logic [31:0] span, logic [23:0] rate);
    rec_t r;
    r.dt = dt; r.alive = alive;
    r.pos_x = p; r.pos_y = ~p; r.pos_z = p ^ 32'h5A5A5A5A;
    r.vel_x = v; r.vel_y = ~v; r.vel_z = v ^ 32'hA5A5A5A5;
    r.age = age; r.span = span; r.spin = 16'hFFF0; r.rate = rate;
    return r;
  endfunction

  initial begin
    grav = '{0, 0, 0};
    drag_q = '0;
    col_s_q = 32'hFFFFFFFF; col_e_q = 32'hFFFFFF00;
    siz_s_q = 32'h00800080; siz_e_q = 32'h001A001A;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, extremes and the death cases
    queue_rec(mk(16'h1000, 1'b1, 32'h00010000, 32'h00020000, 0, 32'h00020000, 24'h010000));
    queue_rec(mk(16'h0000, 1'b1, 0, 0, 0, 32'h00010000, 24'h7FFFFF));
    queue_rec(mk(16'hFFFF, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, 24'h800000));
    queue_rec(mk(16'hFFFF, 1'b1, 32'h80000000, 32'h80000000, 0, 32'hFFFFFFFF, 24'h7FFFFF));
    queue_rec(mk(16'h0100, 1'b0, 32'h12345678, 32'h9ABCDEF0, 32'h5, 32'h100, 24'h1));
    queue_rec(mk(16'h0100, 1'b1, 32'h1, 32'h2, 32'hFF00, 32'h10000, 24'h1));
    queue_rec(mk(16'h0100, 1'b1, 32'h1, 32'h2, 32'hFEFF, 32'h10000, 24'h1));
    queue_rec(mk(16'h0001, 1'b1, 32'h1, 32'h2, 0, 0, 24'h1));
    queue_rec(mk(16'hFFFF, 1'b1, 32'h1, 32'h2, 32'hFFFFFFF0, 32'hFFFFFFFF, 24'h1));
    queue_rec(mk(16'h0010, 1'b1, 32'h1, 32'h2, 32'hFFFFFFF0, 32'hFFFFFFFF, 24'h1));
    queue_rec(mk(16'h8000, 1'b1, 32'hFFFF0000, 32'hFFFF8000, 32'h10000, 32'h30000,
                 24'hFF8000));
    drain();

    // extreme gravity and heavy drag, clamped factor
    write_reg(REG_GRAVITY_X, 32'h7FFFFFFF);
    write_reg(REG_GRAVITY_Y, 32'h80000000);
    write_reg(REG_GRAVITY_Z, 32'hFFFF0000);
    write_reg(REG_DRAG_RATE, 32'h00FFFFFF);
    write_reg(REG_COLOR_START, 32'h00FF00FF);
    write_reg(REG_COLOR_END, 32'hFF00FF00);
    write_reg(REG_SIZE_START, 32'hFFFF0000);
    write_reg(REG_SIZE_END, 32'h0000FFFF);
    for (int i = 0; i < 10; i++) queue_rec(rand_rec());
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_GRAVITY_X, edgy32());
      write_reg(REG_GRAVITY_Y, edgy32());
      write_reg(REG_GRAVITY_Z, edgy32());
      write_reg(REG_DRAG_RATE, (ph == 0) ? 32'h0 : (ph == 1) ? 32'h00008000 : $urandom);
      write_reg(REG_COLOR_START, $urandom);
      write_reg(REG_COLOR_END, $urandom);
      write_reg(REG_SIZE_START, (ph == 3) ? 32'h0 : $urandom);
      write_reg(REG_SIZE_END, (ph == 3) ? 32'hFFFFFFFF : $urandom);
      for (int i = 0; i < 130; i++) queue_rec(rand_rec());
      if (ph == 1) hold_off = 1000;   // receiver stalls, pipeline fills
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && expected_upd.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
